// ===== rtl/core/modbus_rtu_request_checker_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef MODBUS_RTU_REQUEST_CHECKER_UNIT_DEFINES_SVH
`define MODBUS_RTU_REQUEST_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MBRC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MBRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/mbrc_pkg.sv =====
package mbrc_pkg;

   // CRC-16 Modbus
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // byte counter
   localparam logic [8:0] COUNT_MAX     = 9'd511;
   localparam logic [8:0] MIN_FRAME     = 9'd4;
   localparam logic [8:0] READ_LEN      = 9'd8;
   localparam logic [8:0] MIN_WRITE_LEN = 9'd10;

   // supported function codes
   localparam logic [7:0] FUNC_READ_COILS  = 8'h01;
   localparam logic [7:0] FUNC_READ_REGS   = 8'h03;
   localparam logic [7:0] FUNC_WRITE_COILS = 8'h0F;
   localparam logic [7:0] FUNC_WRITE_REGS  = 8'h10;

   // quantity limits per function
   localparam logic [10:0] QTY_MAX_READ_COILS  = 11'd2000;
   localparam logic [10:0] QTY_MAX_READ_REGS   = 11'd125;
   localparam logic [10:0] QTY_MAX_WRITE_COILS = 11'd1968;
   localparam logic [10:0] QTY_MAX_WRITE_REGS  = 11'd123;

   // address range
   localparam logic [15:0] ADDR_MAX = 16'd9999;
   localparam logic [16:0] ADDR_END = 17'd10000;

   // status codes
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_SHORT     = 3'd1;
   localparam logic [2:0] STATUS_CRC       = 3'd2;
   localparam logic [2:0] STATUS_STATION   = 3'd3;
   localparam logic [2:0] STATUS_FUNCTION  = 3'd4;
   localparam logic [2:0] STATUS_LENGTH    = 3'd5;
   localparam logic [2:0] STATUS_QUANTITY  = 3'd6;
   localparam logic [2:0] STATUS_ADDRESS   = 3'd7;

   // configuration registers
   localparam logic       CSR_STATION_ADDRESS = 1'b0;
   localparam logic [7:0] STATION_RESET       = 8'h01;

   // frame summary handed to the status decode
   typedef struct packed {
      logic [15:0] crc;
      logic [8:0]  count;
      logic [7:0]  station;
      logic [7:0]  func;
      logic [15:0] start_addr;
      logic [15:0] quantity;
   } mbrc_frame_type;

   // one byte through the reflected CRC, bit by bit
   function automatic logic [15:0] mbrc_crc_byte(input logic [15:0] crc,
                                                 input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/mbrc_channels.sv =====
// Request channel: one frame byte per item.
interface mbrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_end;

   modport source (output valid, output data_byte, output frame_end, input ready);
   modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

// Response channel: one status per frame.
interface mbrc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;

   modport source (output valid, output status, input ready);
   modport sink   (input valid, input status, output ready);
endinterface

// ===== rtl/core/mbrc_judge.sv =====
module mbrc_judge
   import mbrc_pkg::*;
(
   input  mbrc_frame_type frame,
   input  logic [7:0]     station_address,
   output logic [2:0]     status
);

   logic [10:0] qty_max;
   logic        exact_len;
   logic        func_ok;
   logic        len_bad;
   logic        qty_bad;
   logic [16:0] end_addr;

   // per-function limits
   always_comb begin
      qty_max   = QTY_MAX_READ_COILS;
      exact_len = 1'b1;
      func_ok   = 1'b1;
      case (frame.func)
         FUNC_READ_COILS: begin
            qty_max   = QTY_MAX_READ_COILS;
            exact_len = 1'b1;
         end
         FUNC_READ_REGS: begin
            qty_max   = QTY_MAX_READ_REGS;
            exact_len = 1'b1;
         end
         FUNC_WRITE_COILS: begin
            qty_max   = QTY_MAX_WRITE_COILS;
            exact_len = 1'b0;
         end
         FUNC_WRITE_REGS: begin
            qty_max   = QTY_MAX_WRITE_REGS;
            exact_len = 1'b0;
         end
         default: begin
            func_ok = 1'b0;
         end
      endcase
   end

   // saturated count never equals 8 and is always >= 10
   assign len_bad  = exact_len ? (frame.count != READ_LEN) : (frame.count < MIN_WRITE_LEN);
   assign qty_bad  = (frame.quantity == 16'd0) || (frame.quantity > {5'd0, qty_max});
   assign end_addr = {1'b0, frame.start_addr} + {1'b0, frame.quantity};

   // first failing check wins
   always_comb begin
      if (frame.count < MIN_FRAME) begin
         status = STATUS_SHORT;
      end else if (frame.crc != 16'h0000) begin
         status = STATUS_CRC;
      end else if (frame.station != station_address) begin
         status = STATUS_STATION;
      end else if (!func_ok) begin
         status = STATUS_FUNCTION;
      end else if (len_bad) begin
         status = STATUS_LENGTH;
      end else if (qty_bad) begin
         status = STATUS_QUANTITY;
      end else if ((frame.start_addr > ADDR_MAX) || (end_addr > ADDR_END)) begin
         status = STATUS_ADDRESS;
      end else begin
         status = STATUS_OK;
      end
   end

endmodule

// ===== rtl/core/modbus_rtu_request_checker_unit.sv =====
// Channel   Dir   Payload                      Moves
// req_bus   in    data_byte[7:0], frame_end    one frame byte
// rsp_bus   out   status[2:0]                  one status, on the last byte
// psel..    in    pwdata[7:0] at paddr 0       station_address
//
// One byte is taken every cycle while req_bus.ready is high; the CRC update,
// header capture and the status decode of the last byte all settle in the
// cycle the byte is taken. The status reaches rsp_bus through a register.
// Output register plus a one-entry skid: req_bus.ready drops only when both
// are full. Synchronous reset clears frame state, station_address to 1.
module modbus_rtu_request_checker_unit
   import mbrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   mbrc_req_if.sink    req_bus,
   mbrc_rsp_if.source  rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [7:0]     station_address_ff;
   logic [15:0]    crc_ff;
   logic [8:0]     byte_count_ff;
   logic [7:0]     station_byte_ff;
   logic [7:0]     function_byte_ff;
   logic [15:0]    start_address_ff;
   logic [15:0]    quantity_ff;

   logic           out_valid_ff, out_valid_in;
   logic [2:0]     out_status_ff, out_status_in;
   logic           skid_valid_ff, skid_valid_in;
   logic [2:0]     skid_status_ff, skid_status_in;

   mbrc_frame_type frame_in;
   logic [2:0]     status_new;
   logic           accept;
   logic           push;
   logic           take;
   logic           csr_write;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == CSR_STATION_ADDRESS) ? {24'd0, station_address_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         station_address_ff <= STATION_RESET;
      end else if (csr_write && (paddr[2] == CSR_STATION_ADDRESS)) begin
         station_address_ff <= pwdata[7:0];
      end
   end

   // handshakes
   assign req_bus.ready = !skid_valid_ff;
   assign accept        = req_bus.valid && req_bus.ready;
   assign push          = accept && req_bus.frame_end;
   assign take          = out_valid_ff && rsp_bus.ready;

   // frame state after this byte
   always_comb begin
      frame_in.crc        = mbrc_crc_byte(crc_ff, req_bus.data_byte);
      frame_in.count      = (byte_count_ff == COUNT_MAX) ? byte_count_ff : byte_count_ff + 9'd1;
      frame_in.station    = station_byte_ff;
      frame_in.func       = function_byte_ff;
      frame_in.start_addr = start_address_ff;
      frame_in.quantity   = quantity_ff;
      case (byte_count_ff)
         9'd0: frame_in.station               = req_bus.data_byte;
         9'd1: frame_in.func                  = req_bus.data_byte;
         9'd2: frame_in.start_addr[15:8]      = req_bus.data_byte;
         9'd3: frame_in.start_addr[7:0]       = req_bus.data_byte;
         9'd4: frame_in.quantity[15:8]        = req_bus.data_byte;
         9'd5: frame_in.quantity[7:0]         = req_bus.data_byte;
         default: begin
         end
      endcase
   end

   mbrc_judge u_judge (
      .frame           (frame_in),
      .station_address (station_address_ff),
      .status          (status_new)
   );

   // frame registers, updated on each byte and cleared at frame end
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff           <= CRC_INIT;
         byte_count_ff    <= 9'd0;
         station_byte_ff  <= 8'd0;
         function_byte_ff <= 8'd0;
         start_address_ff <= 16'd0;
         quantity_ff      <= 16'd0;
      end else if (accept) begin
         if (req_bus.frame_end) begin
            crc_ff           <= CRC_INIT;
            byte_count_ff    <= 9'd0;
            station_byte_ff  <= 8'd0;
            function_byte_ff <= 8'd0;
            start_address_ff <= 16'd0;
            quantity_ff      <= 16'd0;
         end else begin
            crc_ff           <= frame_in.crc;
            byte_count_ff    <= frame_in.count;
            station_byte_ff  <= frame_in.station;
            function_byte_ff <= frame_in.func;
            start_address_ff <= frame_in.start_addr;
            quantity_ff      <= frame_in.quantity;
         end
      end
   end

   // output register and skid entry
   always_comb begin
      out_valid_in   = out_valid_ff;
      out_status_in  = out_status_ff;
      skid_valid_in  = skid_valid_ff;
      skid_status_in = skid_status_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_status_in = skid_status_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_valid_ff && !take) begin
         if (push) begin
            skid_valid_in  = 1'b1;
            skid_status_in = status_new;
         end
      end else begin
         out_valid_in = push;
         if (push) begin
            out_status_in = status_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff  <= out_status_in;
      skid_status_ff <= skid_status_in;
   end

   assign rsp_bus.valid  = out_valid_ff;
   assign rsp_bus.status = out_status_ff;

endmodule

// ===== rtl/core/mbrc_checker.sv =====
`include "modbus_rtu_request_checker_unit_defines.svh"

module mbrc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_frame_end,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status
);

   logic req_last;

   assign req_last = req_valid && req_ready && req_frame_end;

   // a stalled status stays put
   `MBRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")
   `MBRC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_status), "rsp status changed while stalled")

   // a status appears only for a frame end taken the cycle before
   `MBRC_ASSERT_NOW(a_rsp_cause, clock, reset, $rose(rsp_valid), $past(req_last), "status without frame end")

   // an empty output shows the status of a frame end in the next cycle
   `MBRC_ASSERT_NEXT(a_rsp_latency, clock, reset, req_last && !rsp_valid, rsp_valid, "status late")

endmodule

bind modbus_rtu_request_checker_unit mbrc_checker u_mbrc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .req_frame_end (req_bus.frame_end),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_status    (rsp_bus.status)
);

// ===== bench/tb_modbus_rtu_request_checker_unit.sv =====
module tb_modbus_rtu_request_checker_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import mbrc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_BYTES = 400;
   localparam int HOLD_CYCLES  = 300;

   logic clock = 1'b0;
   logic reset;

   mbrc_req_if req_bus ();
   mbrc_rsp_if rsp_bus ();

   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   modbus_rtu_request_checker_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #1 clock = ~clock;

   // frame tracking state of the predictor
   logic [7:0]  station_cfg = STATION_RESET;
   logic [15:0] frm_crc     = CRC_INIT;
   logic [8:0]  frm_count   = '0;
   logic [7:0]  frm_station = '0;
   logic [7:0]  frm_func    = '0;
   logic [15:0] frm_start   = '0;
   logic [15:0] frm_qty     = '0;

   logic [2:0] status_expected_q[$];
   logic [2:0] want_status;
   logic [7:0] frame_bytes[$];

   int error_count   = 0;
   int cycle_count   = 0;
   int bytes_sent    = 0;
   bit tx_gaps_on    = 1'b1;
   bit rx_stalls_on  = 1'b1;
   int rx_wait       = 0;
   int rx_hold_cycles = 0;

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------
   function automatic logic [15:0] crc16_modbus_next(logic [15:0] crc, logic [7:0] b);
      logic [15:0] r;
      r = crc ^ {8'h00, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
   endfunction

   function automatic void clear_frame_state();
      frm_crc     = CRC_INIT;
      frm_count   = '0;
      frm_station = '0;
      frm_func    = '0;
      frm_start   = '0;
      frm_qty     = '0;
   endfunction

   // status of the frame just closed, first failing check wins
   function automatic logic [2:0] judge_frame();
      logic [10:0] qmax;
      bit          read_kind;
      if (frm_count < MIN_FRAME) return STATUS_SHORT;
      if (frm_crc != 16'h0000) return STATUS_CRC;
      if (frm_station != station_cfg) return STATUS_STATION;
      case (frm_func)
         FUNC_READ_COILS: begin
            qmax = QTY_MAX_READ_COILS;  read_kind = 1'b1;
         end
         FUNC_READ_REGS: begin
            qmax = QTY_MAX_READ_REGS;   read_kind = 1'b1;
         end
         FUNC_WRITE_COILS: begin
            qmax = QTY_MAX_WRITE_COILS; read_kind = 1'b0;
         end
         FUNC_WRITE_REGS: begin
            qmax = QTY_MAX_WRITE_REGS;  read_kind = 1'b0;
         end
         default: return STATUS_FUNCTION;
      endcase
      // saturated count is never 8 and always passes the write minimum
      if (read_kind ? (frm_count != READ_LEN) : (frm_count < MIN_WRITE_LEN))
         return STATUS_LENGTH;
      if (frm_qty == 16'd0 || frm_qty > {5'd0, qmax}) return STATUS_QUANTITY;
      if (frm_start > ADDR_MAX) return STATUS_ADDRESS;
      if (({1'b0, frm_start} + {1'b0, frm_qty}) > ADDR_END) return STATUS_ADDRESS;
      return STATUS_OK;
   endfunction

   function automatic void track_request_byte(logic [7:0] b, logic last);
      case (frm_count)
         9'd0: frm_station = b;
         9'd1: frm_func = b;
         9'd2: frm_start[15:8] = b;
         9'd3: frm_start[7:0] = b;
         9'd4: frm_qty[15:8] = b;
         9'd5: frm_qty[7:0] = b;
         default: ;
      endcase
      frm_crc = crc16_modbus_next(frm_crc, b);
      if (frm_count != COUNT_MAX) frm_count = frm_count + 9'd1;
      if (last) begin
         status_expected_q.push_back(judge_frame());
         clear_frame_state();
      end
   endfunction

   // ---------------------------------------------------------------
   // result checking and byte tracking, sampled at the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (status_expected_q.size() == 0) begin
               $error("status: no item expected, actual %0d", rsp_bus.status);
               error_count++;
            end else begin
               want_status = status_expected_q.pop_front();
               if (rsp_bus.status !== want_status) begin
                  $error("status: expected %0d actual %0d", want_status, rsp_bus.status);
                  error_count++;
               end
            end
            rx_wait = rx_stalls_on ? $urandom_range(0, 15) : 0;
         end
         if (req_bus.valid && req_bus.ready)
            track_request_byte(req_bus.data_byte, req_bus.frame_end);
      end
   end

   // result side ready, with per-item stalls and the long hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_cycles > 0) begin
            rsp_bus.ready = 1'b0;
            rx_hold_cycles--;
         end else if (rx_wait > 0) begin
            rsp_bus.ready = 1'b0;
            rx_wait--;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------
   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = tx_gaps_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.data_byte = b;
      req_bus.frame_end = last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   // CRC goes out low byte first
   function automatic void append_crc();
      logic [15:0] c;
      c = CRC_INIT;
      foreach (frame_bytes[i]) c = crc16_modbus_next(c, frame_bytes[i]);
      frame_bytes.push_back(c[7:0]);
      frame_bytes.push_back(c[15:8]);
   endfunction

   function automatic void build_request(logic [7:0] stn, logic [7:0] func,
                                         logic [15:0] start, logic [15:0] qty, int extra);
      frame_bytes.delete();
      frame_bytes.push_back(stn);
      frame_bytes.push_back(func);
      frame_bytes.push_back(start[15:8]);
      frame_bytes.push_back(start[7:0]);
      frame_bytes.push_back(qty[15:8]);
      frame_bytes.push_back(qty[7:0]);
      repeat (extra) frame_bytes.push_back(8'($urandom_range(0, 255)));
      append_crc();
   endfunction

   task automatic send_request(input logic [7:0] stn, input logic [7:0] func,
                               input logic [15:0] start, input logic [15:0] qty,
                               input int extra);
      build_request(stn, func, start, qty, extra);
      send_frame();
   endtask

   // idles the request side until every pending status has come back, then drains
   task automatic wait_for_results();
      req_bus.valid     = 1'b0;
      req_bus.frame_end = 1'b0;
      while (status_expected_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // APB write: setup then access, starts at a falling edge
   task automatic write_station(input logic [7:0] value);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {CSR_STATION_ADDRESS, 2'b00};
      pwdata  = {24'd0, value};
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      station_cfg = value;
   endtask

   function automatic int qty_ceiling(logic [7:0] func);
      case (func)
         FUNC_READ_COILS:  return int'(QTY_MAX_READ_COILS);
         FUNC_READ_REGS:   return int'(QTY_MAX_READ_REGS);
         FUNC_WRITE_COILS: return int'(QTY_MAX_WRITE_COILS);
         default:          return int'(QTY_MAX_WRITE_REGS);
      endcase
   endfunction

   function automatic bit is_read_func(logic [7:0] func);
      return func == FUNC_READ_COILS || func == FUNC_READ_REGS;
   endfunction

   function automatic bit is_known_func(logic [7:0] func);
      return is_read_func(func) || func == FUNC_WRITE_COILS || func == FUNC_WRITE_REGS;
   endfunction

   // mostly well-formed requests with random content, the rest broken or noise
   task automatic send_random_request();
      int          pick;
      int          qmax;
      int          extra;
      int          n;
      int          idx;
      logic [7:0]  func;
      logic [7:0]  stn;
      logic [15:0] start;
      logic [15:0] qty;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
         0: func = FUNC_READ_COILS;
         1: func = FUNC_READ_REGS;
         2: func = FUNC_WRITE_COILS;
         default: func = FUNC_WRITE_REGS;
      endcase
      qmax  = qty_ceiling(func);
      qty   = 16'($urandom_range(1, qmax));
      start = 16'($urandom_range(0, 10000 - int'(qty)));
      extra = is_read_func(func) ? 0 : $urandom_range(2, 12);
      stn   = station_cfg;
      if (pick >= 60 && pick < 64) begin
         stn = stn ^ 8'($urandom_range(1, 255));
      end else if (pick >= 64 && pick < 68) begin
         do func = 8'($urandom_range(0, 255)); while (is_known_func(func));
      end else if (pick >= 68 && pick < 74) begin
         extra = is_read_func(func) ? $urandom_range(1, 8) : $urandom_range(0, 1);
      end else if (pick >= 74 && pick < 80) begin
         qty = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(qmax + 1, 65535));
      end else if (pick >= 80 && pick < 86) begin
         if ($urandom_range(0, 1) || qty < 16'd2)
            start = 16'($urandom_range(10000, 65535));
         else
            start = 16'($urandom_range(10001 - int'(qty), 9999));
      end
      build_request(stn, func, start, qty, extra);
      if (pick >= 55 && pick < 60) begin
         // single flipped bit anywhere in the frame
         idx = $urandom_range(0, frame_bytes.size() - 1);
         frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
      end else if (pick >= 86 && pick < 92) begin
         // short frame, often with a good CRC so it gets past the CRC check
         n = $urandom_range(1, 5);
         frame_bytes.delete();
         repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1)) frame_bytes[0] = station_cfg;
         if (n > 1 && $urandom_range(0, 1)) frame_bytes[1] = func;
         if ($urandom_range(0, 2) != 0) append_crc();
      end else if (pick >= 92) begin
         n = $urandom_range(1, 24);
         frame_bytes.delete();
         repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
      send_frame();
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------
   // one frame per status, field extremes, station at its reset value
   task automatic test_status_codes();
      // accepted requests at the range limits
      send_request(STATION_RESET, FUNC_READ_COILS, 16'd0, 16'd2000, 0);
      send_request(STATION_RESET, FUNC_READ_REGS, 16'd9999, 16'd1, 0);
      send_request(STATION_RESET, FUNC_WRITE_COILS, 16'd8032, 16'd1968, 2);
      send_request(STATION_RESET, FUNC_WRITE_REGS, 16'd9877, 16'd123, 4);
      // too short: one byte, and three bytes with a good CRC
      frame_bytes.delete();
      frame_bytes.push_back(8'hFF);
      send_frame();
      frame_bytes.delete();
      frame_bytes.push_back(STATION_RESET);
      append_crc();
      send_frame();
      // four bytes with a good CRC: never-received header stays zero, length rejects it
      frame_bytes.delete();
      frame_bytes.push_back(STATION_RESET);
      frame_bytes.push_back(FUNC_WRITE_REGS);
      append_crc();
      send_frame();
      // corrupted CRC
      build_request(STATION_RESET, FUNC_READ_REGS, 16'd10, 16'd5, 0);
      frame_bytes[3] = frame_bytes[3] ^ 8'h10;
      send_frame();
      send_request(8'h02, FUNC_READ_REGS, 16'd10, 16'd5, 0);
      send_request(STATION_RESET, 8'h00, 16'd10, 16'd5, 0);
      send_request(STATION_RESET, 8'hFF, 16'd10, 16'd5, 0);
      send_request(STATION_RESET, FUNC_READ_COILS, 16'd0, 16'd10, 1);
      send_request(STATION_RESET, FUNC_WRITE_REGS, 16'd0, 16'd10, 1);
      send_request(STATION_RESET, FUNC_READ_COILS, 16'd0, 16'd0, 0);
      send_request(STATION_RESET, FUNC_READ_REGS, 16'd0, 16'd126, 0);
      send_request(STATION_RESET, FUNC_WRITE_COILS, 16'd0, 16'd1969, 3);
      send_request(STATION_RESET, FUNC_WRITE_REGS, 16'd0, 16'd124, 3);
      send_request(STATION_RESET, FUNC_WRITE_REGS, 16'd0, 16'hFFFF, 3);
      send_request(STATION_RESET, FUNC_READ_REGS, 16'd10000, 16'd1, 0);
      send_request(STATION_RESET, FUNC_WRITE_REGS, 16'd9878, 16'd123, 2);
      send_request(STATION_RESET, FUNC_READ_COILS, 16'hFFFF, 16'd1, 0);
   endtask

   // byte counter saturation: 520 bytes would wrap to 8 and pass as a read
   task automatic test_long_frames();
      send_request(station_cfg, FUNC_READ_REGS, 16'd0, 16'd1, 512);
      send_request(station_cfg, FUNC_READ_COILS, 16'd0, 16'd8, 2);
   endtask

   // station register at both ends of its range
   task automatic test_station_setting();
      wait_for_results();
      write_station(8'h00);
      send_request(8'h00, FUNC_READ_REGS, 16'd5, 16'd7, 0);
      send_request(STATION_RESET, FUNC_READ_REGS, 16'd5, 16'd7, 0);
      wait_for_results();
      write_station(8'hFF);
      send_request(8'hFF, FUNC_WRITE_REGS, 16'd5, 16'd7, 5);
      send_request(8'h00, FUNC_WRITE_REGS, 16'd5, 16'd7, 5);
   endtask

   // output held off long enough that the block fills and stalls its input
   task automatic test_backpressure();
      wait_for_results();
      tx_gaps_on     = 1'b0;
      rx_hold_cycles = HOLD_CYCLES;
      repeat (16) begin
         frame_bytes.delete();
         frame_bytes.push_back(8'($urandom_range(0, 255)));
         send_frame();
      end
      repeat (4) send_random_request();
      wait_for_results();
      repeat (4) send_random_request();
      tx_gaps_on = 1'b1;
   endtask

   // random requests in phases, each with its own station and idling mix
   task automatic test_random_requests();
      int first_count;
      int phase;
      first_count = bytes_sent;
      phase = 0;
      while (bytes_sent - first_count < RANDOM_BYTES) begin
         wait_for_results();
         write_station(8'($urandom_range(0, 255)));
         tx_gaps_on   = phase[0];
         rx_stalls_on = phase[1];
         repeat (10) send_random_request();
         phase++;
      end
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;
   endtask

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.frame_end = 1'b0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      reset   = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_status_codes();
      test_long_frames();
      test_station_setting();
      test_backpressure();
      test_random_requests();
      wait_for_results();

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
